// ----- sv/vmde_pkg.sv -----
// Shared sizes, widths and register indexes for the volume dilate/erode block.
package vmde_pkg;

   localparam int MAX_DEPTH  = 1024;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   localparam int DEPTH_W  = 11;
   localparam int SIZE_W   = 9;
   localparam int LABEL_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;

   localparam int SLICE_MAX = MAX_WIDTH * MAX_HEIGHT;
   localparam int SADDR_W   = $clog2(SLICE_MAX);
   localparam int RADDR_W   = $clog2(MAX_HEIGHT);
   localparam int SLICE_W   = $clog2(SLICE_MAX + 1);
   localparam int LAG_W     = $clog2(SLICE_MAX + MAX_HEIGHT + 2);
   localparam int OD_W      = $clog2(MAX_DEPTH);
   localparam int OW_W      = $clog2(MAX_WIDTH);
   localparam int OH_W      = $clog2(MAX_HEIGHT);

   localparam int SWORD_W = LABEL_W + 3;   // {allowed, label, region(q), region(q-slice)}
   localparam int RWORD_W = LABEL_W + 7;   // {allowed, label, column row 0, column row 1}

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE   = 3'd0,
      CSR_TAG    = 3'd1,
      CSR_DEPTH  = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_index_type;

   localparam logic MODE_DILATE = 1'b0;

endpackage

// ----- sv/volume_morph_dilate_erode.sv -----
// Streaming 3x3x3 binary dilate/erode of a tagged label region, top level.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------
//   req     | in        | req_valid/req_ready, req_label_in, req_allowed
//   rsp     | out       | rsp_valid/rsp_ready, rsp_label_out, rsp_last_voxel
//   csr     | in        | csr_valid/csr_ready, csr_index, csr_wdata
//
// One request per cycle while req_ready is high; a result leaves once the request that is
// one slice plus one row plus one voxel later has passed slice buffer read, then update.
// The slice buffer and the row buffer are each read and written at most once per cycle.
// Synchronous reset clears control state; both buffers need no clearing.
// req_ready drops only when the 3-entry output queue plus update stage hold 3 items.
module volume_morph_dilate_erode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vmde_pkg::LABEL_W-1:0]        req_label_in,
   input  logic                                req_allowed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vmde_pkg::LABEL_W-1:0]        rsp_label_out,
   output logic                                rsp_last_voxel,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vmde_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vmde_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LW = vmde_pkg::LABEL_W;

   // configuration
   logic                          mode_ff;
   logic [LW-1:0]                 tag_ff;
   logic [vmde_pkg::DEPTH_W-1:0]  dsz_ff;
   logic [vmde_pkg::SIZE_W-1:0]   wsz_ff;
   logic [vmde_pkg::SIZE_W-1:0]   hsz_ff;
   logic                          csr_write;
   logic                          restart;

   logic [vmde_pkg::DEPTH_W-1:0]  nd;
   logic [vmde_pkg::SIZE_W-1:0]   nw;
   logic [vmde_pkg::SIZE_W-1:0]   nh;
   logic [2*vmde_pkg::SIZE_W-1:0] slice_prod;
   logic [vmde_pkg::SLICE_W-1:0]  slice;
   logic [vmde_pkg::LAG_W-1:0]    lag;

   // input side
   logic                          req_accept;
   logic [vmde_pkg::SADDR_W-1:0]  qs_ff;
   logic [vmde_pkg::RADDR_W-1:0]  qh_ff;

   // update stage
   logic                          s1_valid_ff;
   logic [LW-1:0]                 s1_lab_ff;
   logic                          s1_alw_ff;
   logic [vmde_pkg::SADDR_W-1:0]  s1_qs_ff;
   logic [vmde_pkg::RADDR_W-1:0]  s1_qh_ff;

   logic [vmde_pkg::SWORD_W-1:0]  slice_mem [vmde_pkg::SLICE_MAX];
   logic [vmde_pkg::RWORD_W-1:0]  row_mem [vmde_pkg::MAX_HEIGHT];
   logic [vmde_pkg::SWORD_W-1:0]  slice_rd_ff;
   logic [vmde_pkg::RWORD_W-1:0]  row_rd_ff;
   logic                          slice_fwd_ff;
   logic                          row_fwd_ff;
   logic [vmde_pkg::SWORD_W-1:0]  slice_fwd_data_ff;
   logic [vmde_pkg::RWORD_W-1:0]  row_fwd_data_ff;
   logic [vmde_pkg::SWORD_W-1:0]  slice_rd;
   logic [vmde_pkg::RWORD_W-1:0]  row_rd;
   logic [vmde_pkg::SWORD_W-1:0]  slice_wdata;
   logic [vmde_pkg::RWORD_W-1:0]  row_wdata;

   logic                          r_q;
   logic [8:0]                    col_q;
   logic [8:0]                    colm1_ff;
   logic [8:0]                    colm2_ff;
   logic [LW:0]                   lab_d_ff;
   logic [26:0]                   nbits;
   logic [26:0]                   nmask;
   logic [2:0]                    okd, okw, okh;
   logic                          any_in, any_out;

   logic [vmde_pkg::LAG_W-1:0]    lag_cnt_ff;
   logic [vmde_pkg::OD_W-1:0]     od_ff;
   logic [vmde_pkg::OW_W-1:0]     ow_ff;
   logic [vmde_pkg::OH_W-1:0]     oh_ff;
   logic                          done_ff;
   logic                          step;
   logic                          emit;
   logic                          is_last;
   logic                          od_end, ow_end, oh_end;
   logic [LW-1:0]                 res;

   // output queue
   logic [LW:0]                   fifo_ff [3];
   logic [1:0]                    wr_ptr_ff;
   logic [1:0]                    rd_ptr_ff;
   logic [1:0]                    cnt_ff;
   logic                          pop;
   logic [2:0]                    occupancy;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      restart = 1'b0;
      if (csr_write) begin
         case (csr_index)
            vmde_pkg::CSR_MODE, vmde_pkg::CSR_TAG, vmde_pkg::CSR_DEPTH,
            vmde_pkg::CSR_WIDTH, vmde_pkg::CSR_HEIGHT: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vmde_pkg::MODE_DILATE;
         tag_ff  <= LW'(1);
         dsz_ff  <= vmde_pkg::DEPTH_W'(1);
         wsz_ff  <= vmde_pkg::SIZE_W'(1);
         hsz_ff  <= vmde_pkg::SIZE_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            vmde_pkg::CSR_MODE:   mode_ff <= csr_wdata[0];
            vmde_pkg::CSR_TAG:    tag_ff  <= csr_wdata[LW-1:0];
            vmde_pkg::CSR_DEPTH:  dsz_ff  <= csr_wdata[vmde_pkg::DEPTH_W-1:0];
            vmde_pkg::CSR_WIDTH:  wsz_ff  <= csr_wdata[vmde_pkg::SIZE_W-1:0];
            vmde_pkg::CSR_HEIGHT: hsz_ff  <= csr_wdata[vmde_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (dsz_ff == '0)
         nd = vmde_pkg::DEPTH_W'(1);
      else if (dsz_ff > vmde_pkg::DEPTH_W'(vmde_pkg::MAX_DEPTH))
         nd = vmde_pkg::DEPTH_W'(vmde_pkg::MAX_DEPTH);
      else
         nd = dsz_ff;
      if (wsz_ff == '0)
         nw = vmde_pkg::SIZE_W'(1);
      else if (wsz_ff > vmde_pkg::SIZE_W'(vmde_pkg::MAX_WIDTH))
         nw = vmde_pkg::SIZE_W'(vmde_pkg::MAX_WIDTH);
      else
         nw = wsz_ff;
      if (hsz_ff == '0)
         nh = vmde_pkg::SIZE_W'(1);
      else if (hsz_ff > vmde_pkg::SIZE_W'(vmde_pkg::MAX_HEIGHT))
         nh = vmde_pkg::SIZE_W'(vmde_pkg::MAX_HEIGHT);
      else
         nh = hsz_ff;
   end

   assign slice_prod = nw * nh;
   assign slice      = slice_prod[vmde_pkg::SLICE_W-1:0];
   assign lag        = vmde_pkg::LAG_W'(slice) + vmde_pkg::LAG_W'(nh) + vmde_pkg::LAG_W'(1);

   // ---------------------------------------------------------------- input
   assign occupancy  = {1'b0, cnt_ff} + {2'b00, s1_valid_ff};
   assign req_ready  = (occupancy < 3'd3);
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         qs_ff <= '0;
         qh_ff <= '0;
      end else if (req_accept) begin
         if (vmde_pkg::SLICE_W'(qs_ff) == slice - vmde_pkg::SLICE_W'(1))
            qs_ff <= '0;
         else
            qs_ff <= qs_ff + vmde_pkg::SADDR_W'(1);
         if (vmde_pkg::SIZE_W'(qh_ff) == nh - vmde_pkg::SIZE_W'(1))
            qh_ff <= '0;
         else
            qh_ff <= qh_ff + vmde_pkg::RADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_lab_ff         <= req_label_in;
         s1_alw_ff         <= req_allowed;
         s1_qs_ff          <= qs_ff;
         s1_qh_ff          <= qh_ff;
         // same entry written by the update stage this cycle: bypass the array
         slice_fwd_ff      <= s1_valid_ff && (s1_qs_ff == qs_ff);
         row_fwd_ff        <= s1_valid_ff && (s1_qh_ff == qh_ff);
         slice_fwd_data_ff <= slice_wdata;
         row_fwd_data_ff   <= row_wdata;
      end
   end

   // ---------------------------------------------------------------- buffers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slice_rd_ff <= slice_mem[qs_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         slice_mem[s1_qs_ff] <= slice_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_rd_ff <= row_mem[qh_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         row_mem[s1_qh_ff] <= row_wdata;
      end
   end

   // ---------------------------------------------------------------- update
   assign slice_rd = slice_fwd_ff ? slice_fwd_data_ff : slice_rd_ff;
   assign row_rd   = row_fwd_ff ? row_fwd_data_ff : row_rd_ff;
   assign r_q      = (s1_lab_ff == tag_ff);

   // column bit a*3+b: region of q - a rows - b slices
   always_comb begin
      col_q[0] = r_q;
      col_q[1] = slice_rd[1];
      col_q[2] = slice_rd[0];
      col_q[5:3] = row_rd[5:3];
      col_q[8:6] = row_rd[2:0];
   end

   assign slice_wdata = {s1_alw_ff, s1_lab_ff, r_q, slice_rd[1]};
   assign row_wdata   = {slice_rd[vmde_pkg::SWORD_W-1:2], col_q[2:0], col_q[5:3]};

   assign oh_end = (vmde_pkg::SIZE_W'(oh_ff) == nh - vmde_pkg::SIZE_W'(1));
   assign ow_end = (vmde_pkg::SIZE_W'(ow_ff) == nw - vmde_pkg::SIZE_W'(1));
   assign od_end = (vmde_pkg::DEPTH_W'(od_ff) == nd - vmde_pkg::DEPTH_W'(1));

   assign okd = {!od_end, 1'b1, od_ff != '0};
   assign okw = {!ow_end, 1'b1, ow_ff != '0};
   assign okh = {!oh_end, 1'b1, oh_ff != '0};

   always_comb begin
      for (int id = 0; id < 3; id++) begin
         for (int iw = 0; iw < 3; iw++) begin
            for (int ih = 0; ih < 3; ih++) begin
               nmask[id*9 + iw*3 + ih] = okd[id] && okw[iw] && okh[ih];
               case (ih)
                  0:       nbits[id*9 + iw*3 + ih] = colm2_ff[(2-iw)*3 + (2-id)];
                  1:       nbits[id*9 + iw*3 + ih] = colm1_ff[(2-iw)*3 + (2-id)];
                  default: nbits[id*9 + iw*3 + ih] = col_q[(2-iw)*3 + (2-id)];
               endcase
            end
         end
      end
   end

   assign any_in  = |(nbits & nmask);
   assign any_out = |(~nbits & nmask);

   assign step    = s1_valid_ff && !done_ff;
   assign emit    = step && (lag_cnt_ff == lag);
   assign is_last = od_end && ow_end && oh_end;

   always_comb begin
      res = lab_d_ff[LW-1:0];
      if (lab_d_ff[LW]) begin
         if (mode_ff == vmde_pkg::MODE_DILATE) begin
            if (any_in) res = tag_ff;
         end else begin
            if ((lab_d_ff[LW-1:0] == tag_ff) && any_out) res = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         colm1_ff <= col_q;
         colm2_ff <= colm1_ff;
         lab_d_ff <= row_rd[vmde_pkg::RWORD_W-1:6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         lag_cnt_ff <= '0;
         od_ff      <= '0;
         ow_ff      <= '0;
         oh_ff      <= '0;
         done_ff    <= 1'b0;
      end else if (step) begin
         if (!emit) begin
            lag_cnt_ff <= lag_cnt_ff + vmde_pkg::LAG_W'(1);
         end else begin
            if (is_last) done_ff <= 1'b1;
            if (oh_end) begin
               oh_ff <= '0;
               if (ow_end) begin
                  ow_ff <= '0;
                  od_ff <= od_ff + vmde_pkg::OD_W'(1);
               end else begin
                  ow_ff <= ow_ff + vmde_pkg::OW_W'(1);
               end
            end else begin
               oh_ff <= oh_ff + vmde_pkg::OH_W'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------- output queue
   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_label_out  = fifo_ff[rd_ptr_ff][LW-1:0];
   assign rsp_last_voxel = fifo_ff[rd_ptr_ff][LW];

   always_ff @(posedge clock) begin
      if (emit) begin
         fifo_ff[wr_ptr_ff] <= {is_last, res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (emit) wr_ptr_ff <= (wr_ptr_ff == 2'd2) ? 2'd0 : wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == 2'd2) ? 2'd0 : rd_ptr_ff + 2'd1;
         if (emit && !pop)
            cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !emit)
            cnt_ff <= cnt_ff - 2'd1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(emit && !pop && cnt_ff == 2'd3))
      else $error("output queue overflow");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !emit)
      else $error("result after last voxel");

   a_stage_follows_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_accept))
      else $error("update stage without request");

   a_last_then_done: assert property (@(posedge clock) disable iff (reset || restart)
      (emit && is_last) |=> done_ff)
      else $error("volume not closed after last voxel");
`endif

endmodule
